@@ hdl/cpr_pkg.sv @@
// Shared types, constants and mode codes for the cuff pressure regulator.
`timescale 1ns / 1ps
`default_nettype none

package cpr_pkg;

    localparam int PRESSURE_BITS = 12;
    localparam int GAIN_BITS     = 8;
    localparam int DUTY_BITS     = 12;
    localparam int MODE_BITS     = 2;
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 12;
    // pressure difference plus headroom for the +1.0 and +-2.0 offsets
    localparam int ERR_BITS      = PRESSURE_BITS + 2;
    localparam int PROD_BITS     = GAIN_BITS + 1 + ERR_BITS;
    localparam int TOTAL_BITS    = DUTY_BITS + 8 + 4;

    localparam logic [DUTY_BITS-1:0] PWM_TOP    = DUTY_BITS'(3999);
    localparam logic [DUTY_BITS-1:0] DUTY_START = DUTY_BITS'(3999 / 2);

    localparam logic signed [ERR_BITS-1:0] ONE_UNIT   = ERR_BITS'(16);
    localparam logic signed [ERR_BITS-1:0] BAND_UNITS = ERR_BITS'(32);

    localparam logic [PRESSURE_BITS-1:0] TARGET_RST = PRESSURE_BITS'(976);
    localparam logic [GAIN_BITS-1:0]     GAIN_RST   = GAIN_BITS'(24);

    localparam logic [CFG_IDX_BITS-1:0] CFG_TARGET = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_GAIN   = CFG_IDX_BITS'(1);

    localparam logic [MODE_BITS-1:0] MODE_ENTRY   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_INFLATE = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_VENT    = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_HOLD    = 2'd3;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic                 low_flag;
        logic [DUTY_BITS-1:0] duty;
        logic [DUTY_BITS-1:0] pwm;
        logic                 valve;
    } t_state;

endpackage

`default_nettype wire

@@ hdl/cpr_in_if.sv @@
// Stream channel carrying one pressure sample word.
`timescale 1ns / 1ps
`default_nettype none

interface cpr_in_if
    import cpr_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [PRESSURE_BITS-1:0] pressure;

    modport source (output valid, output pressure, input ready);
    modport sink   (input valid, input pressure, output ready);
endinterface

`default_nettype wire

@@ hdl/cpr_out_if.sv @@
// Stream channel carrying one regulator result word.
`timescale 1ns / 1ps
`default_nettype none

interface cpr_out_if
    import cpr_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [DUTY_BITS-1:0] pwm_compare;
    logic                 inflate_valve;
    logic [MODE_BITS-1:0] mode;

    modport source (output valid, output pwm_compare, output inflate_valve,
                    output mode, input ready);
    modport sink   (input valid, input pwm_compare, input inflate_valve,
                    input mode, output ready);
endinterface

`default_nettype wire

@@ hdl/cpr_duty.sv @@
// Incremental proportional duty update with clamping to 0..PWM_TOP.
`timescale 1ns / 1ps
`default_nettype none

module cpr_duty
    import cpr_pkg::*;
(
    input  wire logic [DUTY_BITS-1:0]     i_duty,
    input  wire logic [GAIN_BITS-1:0]     i_gain,
    input  wire logic [PRESSURE_BITS-1:0] i_pressure,
    input  wire logic [PRESSURE_BITS-1:0] i_target,
    output      logic [DUTY_BITS-1:0]     o_duty
);

    logic signed [ERR_BITS-1:0]   err;
    logic signed [PROD_BITS-1:0]  prod;
    logic signed [TOTAL_BITS-1:0] total;
    logic [TOTAL_BITS-9:0]        shifted;

    always_comb begin
        err   = $signed({2'b00, i_target}) + ONE_UNIT
              - $signed({2'b00, i_pressure});
        // Q4.4 gain times signed Q10.4 error gives signed Q15.8
        prod  = $signed({1'b0, i_gain}) * err;
        total = $signed({4'b0000, i_duty, 8'h00})
              + TOTAL_BITS'(prod);
        shifted = total[TOTAL_BITS-1:8];
        if (total[TOTAL_BITS-1]) begin
            o_duty = '0;
        end else if (shifted > (TOTAL_BITS-8)'(PWM_TOP)) begin
            o_duty = PWM_TOP;
        end else begin
            o_duty = shifted[DUTY_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

@@ hdl/cpr_ctrl.sv @@
// Mode machine with hysteresis band: next state from one pressure sample.
`timescale 1ns / 1ps
`default_nettype none

module cpr_ctrl
    import cpr_pkg::*;
(
    input  wire logic [PRESSURE_BITS-1:0] i_pressure,
    input  wire logic [PRESSURE_BITS-1:0] i_target,
    input  wire logic [GAIN_BITS-1:0]     i_gain,
    input  wire t_state                   i_state,
    output      t_state                   o_state
);

    logic [DUTY_BITS-1:0]       duty_upd;
    logic signed [ERR_BITS-1:0] ps;
    logic signed [ERR_BITS-1:0] ss;
    logic                       at_low;
    logic                       le_one;
    logic                       above_band;
    logic                       in_band;
    logic [MODE_BITS-1:0]       route;
    logic                       low_now;

    cpr_duty u_duty (
        .i_duty     (i_state.duty),
        .i_gain     (i_gain),
        .i_pressure (i_pressure),
        .i_target   (i_target),
        .o_duty     (duty_upd)
    );

    always_comb begin
        ps = $signed({2'b00, i_pressure});
        ss = $signed({2'b00, i_target});
        // signed compares: a band edge below zero is never reached
        at_low     = ps <= ss - BAND_UNITS;
        le_one     = ps <= ss + ONE_UNIT;
        above_band = ps > ss + BAND_UNITS;
        in_band    = (ps >= ss - BAND_UNITS) && !above_band;

        priority if (above_band) begin
            route = MODE_VENT;
        end else if (in_band) begin
            route = MODE_HOLD;
        end else begin
            route = MODE_ENTRY;
        end

        low_now = i_state.low_flag | at_low;
        o_state = i_state;

        unique case (i_state.mode)
            MODE_ENTRY: begin
                o_state.duty = duty_upd;
                if (low_now) begin
                    o_state.duty = DUTY_START;
                    if (le_one) begin
                        o_state.mode     = MODE_INFLATE;
                        o_state.low_flag = 1'b1;
                    end else begin
                        o_state.mode     = route;
                        o_state.low_flag = 1'b0;
                    end
                end else begin
                    o_state.mode = route;
                end
            end
            MODE_INFLATE: begin
                o_state.duty  = duty_upd;
                o_state.valve = 1'b1;
                o_state.pwm   = duty_upd;
                if (!le_one) begin
                    o_state.low_flag = 1'b0;
                    o_state.mode     = route;
                end
            end
            MODE_VENT: begin
                o_state.duty  = duty_upd;
                o_state.valve = 1'b0;
                o_state.pwm   = '0;
                if (!above_band) begin
                    o_state.mode = route;
                end
            end
            MODE_HOLD: begin
                o_state.duty  = '0;
                o_state.pwm   = '0;
                o_state.valve = 1'b0;
                if (!in_band) begin
                    o_state.mode = MODE_ENTRY;
                end
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/cuff_pressure_regulator.sv @@
// A sample word is accepted into the input register, and its result word is
// loaded into the result register once that is free or being drained.
// Throughput: one sample word per cycle while the sink takes each result; the
// state update through the duty multiply-accumulate and mode compare sets that rate.
// Reset (synchronous, active low): mode entry, low flag set, duty, PWM and
// valve cleared, target 61.0 and gain 1.5, both stages empty.
`timescale 1ns / 1ps
`default_nettype none

module cuff_pressure_regulator
    import cpr_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    cpr_in_if.sink                        i_in,
    cpr_out_if.source                     o_out,
    input  wire logic                     i_cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // Configuration registers
    logic [PRESSURE_BITS-1:0] r_target;
    logic [GAIN_BITS-1:0]     r_gain;

    // Input stage: holds one sample word
    logic                     r_in_valid;
    logic [PRESSURE_BITS-1:0] r_in_pressure;

    // Regulator state, updated once per processed sample
    t_state                   r_state;
    t_state                   n_state;

    // Result stage
    logic                     r_out_valid;
    logic [DUTY_BITS-1:0]     r_out_pwm;
    logic                     r_out_valve;
    logic [MODE_BITS-1:0]     r_out_mode;

    logic                     advance;
    logic                     in_take;

    // Advance the input stage into the result stage whenever the result
    // slot is free or being drained this cycle.
    assign advance = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;
    assign in_take = i_in.valid && i_in.ready;

    cpr_ctrl u_ctrl (
        .i_pressure (r_in_pressure),
        .i_target   (r_target),
        .i_gain     (r_gain),
        .i_state    (r_state),
        .o_state    (n_state)
    );

    // The user must write configuration only while idle; the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= TARGET_RST;
            r_gain   <= GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TARGET: r_target <= i_cfg_data[PRESSURE_BITS-1:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_BITS-1:0];
                default:    r_gain   <= r_gain;
            endcase
        end
    end

    // Input register: load a new word, or drop the flag once it moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_pressure <= i_in.pressure;
        end
    end

    // State commit: one sample word per advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode     <= MODE_ENTRY;
            r_state.low_flag <= 1'b1;
            r_state.duty     <= '0;
            r_state.pwm      <= '0;
            r_state.valve    <= 1'b0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: hold until taken, refill on advance.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_pwm   <= n_state.pwm;
            r_out_valve <= n_state.valve;
            r_out_mode  <= n_state.mode;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.pwm_compare   = r_out_pwm;
    assign o_out.inflate_valve = r_out_valve;
    assign o_out.mode          = r_out_mode;

endmodule

`default_nettype wire
